FILE: rtl/core/mptw_pkg.sv
// Package for the multilevel page table walker: sizes, codes and the
// command and status structs between controller and datapath.
// Depends on nothing; every other file of the block but mptw_ram imports it.
package mptw_pkg;

  localparam int NUM_LEVELS       = 4;
  localparam int PAGE_OFFSET_BITS = 12;
  localparam int NUM_FRAMES       = 64;

  localparam int VA_W     = 48;
  localparam int PA_W     = 18;
  localparam int STATUS_W = 2;

  localparam int ENTRY_BITS   = PAGE_OFFSET_BITS - 3;
  localparam int ENTRIES      = 1 << ENTRY_BITS;
  localparam int IDX_FULL     = NUM_LEVELS * ENTRY_BITS;
  localparam int IDX_TOTAL    = (IDX_FULL > 64 - PAGE_OFFSET_BITS) ?
                                (64 - PAGE_OFFSET_BITS) / NUM_LEVELS : IDX_FULL;
  localparam int IDX_SIZE     = IDX_TOTAL / NUM_LEVELS;
  localparam int FRAME_W      = $clog2(NUM_FRAMES);
  localparam int ENT_W        = FRAME_W + 1;
  localparam int ADDR_W       = FRAME_W + ENTRY_BITS;
  localparam int STORE_DEPTH  = NUM_FRAMES * ENTRIES;
  localparam int NFF_W        = $clog2(NUM_FRAMES + 1);
  localparam int LVL_W        = (NUM_LEVELS > 1) ? $clog2(NUM_LEVELS) : 1;

  localparam logic REQ_TRANSLATE = 1'b0;
  localparam logic REQ_ALLOCATE  = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    RES_OK       = 2'd0,
    RES_UNMAPPED = 2'd1,
    RES_NOFRAME  = 2'd2
  } res_e;

  typedef enum logic [5:0] {
    ST_CLEAR = 6'b000001,
    ST_IDLE  = 6'b000010,
    ST_START = 6'b000100,
    ST_READ  = 6'b001000,
    ST_EVAL  = 6'b010000,
    ST_DONE  = 6'b100000
  } state_e;

  typedef struct packed {
    logic load;
    logic clr_step;
    logic root_alloc;
    logic descend;
    logic alloc_entry;
    logic next_level;
    logic finish;
    res_e res;
  } mptw_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic root_present;
    logic frames_left;
    logic is_alloc;
    logic entry_valid;
    logic last_level;
    logic out_free;
  } mptw_sts_t;

endpackage

FILE: rtl/core/mptw_ifs.sv
// Request and response channel interfaces of the page table walker.
// Depends on mptw_pkg for the payload widths.
interface mptw_req_if import mptw_pkg::*; ();
  logic            valid;
  logic            ready;
  logic            req_type;
  logic [VA_W-1:0] virtual_address;

  modport source (output valid, req_type, virtual_address, input ready);
  modport sink   (input valid, req_type, virtual_address, output ready);
endinterface

interface mptw_rsp_if import mptw_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [PA_W-1:0]     physical_address;
  logic [STATUS_W-1:0] status;

  modport source (output valid, physical_address, status, input ready);
  modport sink   (input valid, physical_address, status, output ready);
endinterface

FILE: rtl/core/mptw_ram.sv
// Generic single-port RAM with a registered read port.
// Depends on nothing.
module mptw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/core/mptw_ctrl.sv
// Controller of the page table walker: sequences clearing, the walk and
// the result hand-off. Depends on mptw_pkg.
module mptw_ctrl import mptw_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  mptw_sts_t sts_i,
  output mptw_cmd_t cmd_o
);

  state_e state_q, state_d;
  res_e   res_q, res_d;

  always_comb begin
    state_d    = state_q;
    res_d      = res_q;
    cmd_o      = '0;
    cmd_o.res  = res_q;
    in_ready_o = 1'b0;
    case (state_q)
      ST_CLEAR: begin
        cmd_o.clr_step = 1'b1;
        if (sts_i.clr_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_START;
        end
      end
      ST_START: begin
        if (sts_i.root_present) begin
          state_d = ST_READ;
        end else if (!sts_i.is_alloc) begin
          res_d   = RES_UNMAPPED;
          state_d = ST_DONE;
        end else if (!sts_i.frames_left) begin
          res_d   = RES_NOFRAME;
          state_d = ST_DONE;
        end else begin
          cmd_o.root_alloc = 1'b1;
          state_d          = ST_READ;
        end
      end
      ST_READ: begin
        state_d = ST_EVAL;
      end
      ST_EVAL: begin
        if (sts_i.entry_valid || (sts_i.is_alloc && sts_i.frames_left)) begin
          cmd_o.descend     = sts_i.entry_valid;
          cmd_o.alloc_entry = !sts_i.entry_valid;
          if (sts_i.last_level) begin
            res_d   = RES_OK;
            state_d = ST_DONE;
          end else begin
            cmd_o.next_level = 1'b1;
            state_d          = ST_READ;
          end
        end else begin
          res_d   = sts_i.is_alloc ? RES_NOFRAME : RES_UNMAPPED;
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      res_q   <= RES_OK;
    end else begin
      state_q <= state_d;
      res_q   <= res_d;
    end
  end

endmodule

FILE: rtl/core/mptw_dp.sv
// Datapath of the page table walker: request registers, frame allocator,
// table store and result register. Depends on mptw_pkg and mptw_ram.
module mptw_dp import mptw_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  mptw_cmd_t           cmd_i,
  output mptw_sts_t           sts_o,
  input  logic                req_type_i,
  input  logic [VA_W-1:0]     virtual_address_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [PA_W-1:0]     physical_address_o,
  output logic [STATUS_W-1:0] status_o
);

  logic                        req_alloc_q;
  logic [IDX_TOTAL-1:0]        span_q;
  logic [PAGE_OFFSET_BITS-1:0] offset_q;
  logic [FRAME_W-1:0]          frame_q, frame_d;
  logic [LVL_W-1:0]            level_q;
  logic [NFF_W-1:0]            next_free_q, next_free_d;
  logic                        root_q, root_d;
  logic [ADDR_W-1:0]           clr_q;
  logic                        out_valid_q;
  logic [PA_W-1:0]             out_pa_q;
  logic [STATUS_W-1:0]         out_status_q;

  logic [63:0]                 va_ext;
  logic [ENTRY_BITS-1:0]       idx_cur;
  logic                        ram_we;
  logic [ADDR_W-1:0]           ram_addr;
  logic [ENT_W-1:0]            ram_wdata;
  logic [ENT_W-1:0]            ram_rdata;
  logic [FRAME_W+PAGE_OFFSET_BITS-1:0] pa_full;

  assign va_ext  = 64'(virtual_address_i);
  assign idx_cur = ENTRY_BITS'(span_q[IDX_TOTAL-1 -: IDX_SIZE]);
  assign pa_full = {frame_q, offset_q};

  always_comb begin
    ram_we    = cmd_i.clr_step | cmd_i.alloc_entry;
    ram_addr  = {frame_q, idx_cur};
    ram_wdata = {next_free_q[FRAME_W-1:0], 1'b1};
    if (cmd_i.clr_step) begin
      ram_addr  = clr_q;
      ram_wdata = '0;
    end
  end

  mptw_ram #(
    .WIDTH (ENT_W),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    frame_d     = frame_q;
    next_free_d = next_free_q;
    root_d      = root_q;
    if (cmd_i.load) begin
      frame_d = '0;
    end
    if (cmd_i.root_alloc) begin
      root_d      = 1'b1;
      next_free_d = next_free_q + NFF_W'(1);
    end
    if (cmd_i.descend) begin
      frame_d = ram_rdata[ENT_W-1:1];
    end
    if (cmd_i.alloc_entry) begin
      frame_d     = next_free_q[FRAME_W-1:0];
      next_free_d = next_free_q + NFF_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      root_q      <= 1'b0;
      next_free_q <= '0;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      root_q      <= root_d;
      next_free_q <= next_free_d;
      if (cmd_i.clr_step) begin
        clr_q <= clr_q + ADDR_W'(1);
      end
      if (cmd_i.finish) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    frame_q <= frame_d;
    if (cmd_i.load) begin
      req_alloc_q <= (req_type_i == REQ_ALLOCATE);
      span_q      <= va_ext[PAGE_OFFSET_BITS +: IDX_TOTAL];
      offset_q    <= virtual_address_i[PAGE_OFFSET_BITS-1:0];
      level_q     <= '0;
    end
    if (cmd_i.next_level) begin
      span_q  <= span_q << IDX_SIZE;
      level_q <= level_q + LVL_W'(1);
    end
    if (cmd_i.finish) begin
      out_status_q <= cmd_i.res;
      out_pa_q     <= (cmd_i.res == RES_OK && !req_alloc_q) ? PA_W'(pa_full) : '0;
    end
  end

  always_comb begin
    sts_o.clr_last     = (clr_q == ADDR_W'(STORE_DEPTH - 1));
    sts_o.root_present = root_q;
    sts_o.frames_left  = (next_free_q < NFF_W'(NUM_FRAMES));
    sts_o.is_alloc     = req_alloc_q;
    sts_o.entry_valid  = ram_rdata[0];
    sts_o.last_level   = (level_q == LVL_W'(NUM_LEVELS - 1));
    sts_o.out_free     = !out_valid_q || out_ready_i;
  end

  assign out_valid_o        = out_valid_q;
  assign physical_address_o = out_pa_q;
  assign status_o           = out_status_q;

endmodule

FILE: rtl/core/multilevel_page_table_walker.sv
// Top level of the multilevel page table walker: joins controller and
// datapath to the request and response channels. Depends on mptw_pkg,
// mptw_ifs, mptw_ctrl and mptw_dp.
//
//   Channel  Dir  Payload                          Handshake
//   req_i    in   req_type, virtual_address        valid / ready
//   rsp_o    out  physical_address, status         valid / ready
//
// One request is walked at a time, with one table read and evaluation per
// level on the single port of the table store; an early fault ends the walk
// sooner. After reset a clearing pass writes all STORE_DEPTH entries, one
// per cycle, and req_i.ready stays low meanwhile. The result register lets
// the next request start while a result waits; a stalled rsp_o only holds
// the walker in ST_DONE.
module multilevel_page_table_walker import mptw_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  mptw_req_if.sink          req_i,
  mptw_rsp_if.source        rsp_o
);

  mptw_cmd_t cmd;
  mptw_sts_t sts;

  mptw_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req_i.valid),
    .in_ready_o (req_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  mptw_dp u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .sts_o              (sts),
    .req_type_i         (req_i.req_type),
    .virtual_address_i  (req_i.virtual_address),
    .out_valid_o        (rsp_o.valid),
    .out_ready_i        (rsp_o.ready),
    .physical_address_o (rsp_o.physical_address),
    .status_o           (rsp_o.status)
  );

endmodule

FILE: bench/multilevel_page_table_walker_tb.sv
// Self-checking testbench for multilevel_page_table_walker: random bursts of translate
// and allocate requests against an in-bench model of the table walk and frame allocator.
// Depends on mptw_pkg, the mptw_ifs interfaces and the walker RTL.
module multilevel_page_table_walker_tb import mptw_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RUN_LIMIT    = 600000;
  localparam int WALK_CYCLES  = 2 * NUM_LEVELS + 3;
  localparam int RANDOM_ITEMS = 1930;

  typedef struct {
    logic            kind;
    logic [VA_W-1:0] va;
  } walk_req_t;

  typedef struct {
    logic [PA_W-1:0] pa;
    res_e            st;
  } walk_result_t;

  typedef enum {RX_FREE, RX_LIGHT, RX_HEAVY} rx_mode_e;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic            drv_valid = 1'b0;
  logic            drv_type  = REQ_TRANSLATE;
  logic [VA_W-1:0] drv_va    = '0;
  logic            drv_rdy   = 1'b0;

  mptw_req_if req_if ();
  mptw_rsp_if rsp_if ();

  assign req_if.valid           = drv_valid;
  assign req_if.req_type        = drv_type;
  assign req_if.virtual_address = drv_va;
  assign rsp_if.ready           = drv_rdy;

  multilevel_page_table_walker dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  walk_req_t    pending_reqs[$];
  walk_result_t walk_results_q[$];
  logic [VA_W-1:0] tried_allocs[$];

  bit [ENT_W-1:0]  model_tbl [STORE_DEPTH];
  bit              model_root = 1'b0;
  logic [NFF_W-1:0] frames_used = '0;

  int err_count   = 0;
  int rsp_count   = 0;
  int cycle_count = 0;

  function automatic void predict_walk(input logic kind, input logic [VA_W-1:0] va,
                                       output walk_result_t r);
    longint unsigned span;
    longint unsigned idx;
    logic [FRAME_W-1:0] frame;
    logic [ENT_W-1:0] ent;
    int unsigned slot_a;
    int lvl;
    r.pa = '0;
    r.st = RES_OK;
    frame = '0;
    span = 64'(va) >> PAGE_OFFSET_BITS;
    span &= (64'd1 << IDX_TOTAL) - 64'd1;
    if (kind == REQ_TRANSLATE && !model_root) begin
      r.st = RES_UNMAPPED;
    end else if (kind == REQ_ALLOCATE && !model_root) begin
      if (frames_used >= NUM_FRAMES) begin
        r.st = RES_NOFRAME;
      end else begin
        frames_used++;
        model_root = 1'b1;
      end
    end
    for (lvl = 0; lvl < NUM_LEVELS && r.st == RES_OK; lvl++) begin
      idx = (span >> (IDX_TOTAL - (lvl + 1) * IDX_SIZE)) & ((64'd1 << IDX_SIZE) - 64'd1);
      idx &= ENTRIES - 1;
      slot_a = int'(frame) * ENTRIES + int'(idx);
      ent = model_tbl[slot_a];
      if (ent[0]) begin
        frame = ent[ENT_W-1:1];
      end else if (kind == REQ_TRANSLATE) begin
        r.st = RES_UNMAPPED;
      end else if (frames_used >= NUM_FRAMES) begin
        r.st = RES_NOFRAME;
      end else begin
        frame = frames_used[FRAME_W-1:0];
        frames_used++;
        model_tbl[slot_a] = {frame, 1'b1};
      end
    end
    if (kind == REQ_TRANSLATE && r.st == RES_OK) begin
      r.pa = PA_W'((64'(frame) << PAGE_OFFSET_BITS) + 64'(va[PAGE_OFFSET_BITS-1:0]));
    end
  endfunction

  task automatic note_error(input string msg);
    if (err_count < 10) $display("ERROR @%0t: %s", $realtime, msg);
    err_count++;
  endtask

  // Driver: bursts of transfers with random gaps between them.
  int unsigned burst_left = 0;
  int unsigned gap_left   = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      drv_valid <= 1'b0;
    end else begin
      if (drv_valid && req_if.ready) void'(pending_reqs.pop_front());
      if (!drv_valid || req_if.ready) begin
        if (gap_left > 0) begin
          gap_left--;
          drv_valid <= 1'b0;
        end else if (pending_reqs.size() > 0) begin
          drv_valid <= 1'b1;
          drv_type  <= pending_reqs[0].kind;
          drv_va    <= pending_reqs[0].va;
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 24);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
          end else begin
            burst_left--;
          end
        end else begin
          drv_valid <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold-offs, so the walker fills up and stalls its request side.
  logic hold_on      = 1'b0;
  int   hold_left    = 0;
  int   next_hold_at = 300;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_on <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      hold_on   <= (hold_left > 1);
    end else if (rsp_count >= next_hold_at) begin
      hold_on      <= 1'b1;
      hold_left    <= $urandom_range(250, 400);
      next_hold_at <= next_hold_at + 700;
    end
  end

  rx_mode_e    rx_mode    = RX_FREE;
  int unsigned rx_phase   = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      drv_rdy <= 1'b0;
    end else begin
      if (rx_phase == 0) begin
        rx_mode  = rx_mode_e'($urandom_range(0, 2));
        rx_phase = $urandom_range(20, 120);
      end else begin
        rx_phase--;
      end
      if (hold_on) begin
        drv_rdy <= 1'b0;
      end else begin
        case (rx_mode)
          RX_FREE:  drv_rdy <= 1'b1;
          RX_LIGHT: drv_rdy <= ($urandom_range(0, 3) != 0);
          default:  drv_rdy <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // Monitor: checks each result transfer, then predicts each request transfer.
  walk_result_t mon_exp;
  walk_result_t mon_new;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (rsp_if.valid && drv_rdy) begin
        rsp_count <= rsp_count + 1;
        if (walk_results_q.size() == 0) begin
          note_error($sformatf("unexpected result pa=%h status=%0d",
                               rsp_if.physical_address, rsp_if.status));
        end else begin
          mon_exp = walk_results_q.pop_front();
          if (rsp_if.physical_address !== mon_exp.pa || rsp_if.status !== mon_exp.st) begin
            note_error($sformatf("result %0d: expected pa=%h status=%s, got pa=%h status=%0d",
                                 rsp_count, mon_exp.pa, mon_exp.st.name(),
                                 rsp_if.physical_address, rsp_if.status));
          end
        end
      end
      if (req_if.valid && req_if.ready) begin
        predict_walk(req_if.req_type, req_if.virtual_address, mon_new);
        walk_results_q.push_back(mon_new);
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= RUN_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  function automatic logic [VA_W-1:0] make_va(input longint unsigned upper,
                                              input longint unsigned leaf,
                                              input longint unsigned off);
    return VA_W'((((upper << IDX_SIZE) | leaf) << PAGE_OFFSET_BITS) | off);
  endfunction

  task automatic queue_req(input logic kind, input logic [VA_W-1:0] va);
    walk_req_t it;
    it.kind = kind;
    it.va   = va;
    pending_reqs.push_back(it);
    if (kind == REQ_ALLOCATE) tried_allocs.push_back(va);
  endtask

  longint unsigned upper_mask;
  longint unsigned leaf_max;
  longint unsigned off_max;
  longint unsigned prefix_pool[8];
  logic [VA_W-1:0] pick_va;
  int unsigned     dice;

  initial begin
    upper_mask = (64'd1 << (IDX_TOTAL - IDX_SIZE)) - 64'd1;
    leaf_max   = (64'd1 << IDX_SIZE) - 64'd1;
    off_max    = (64'd1 << PAGE_OFFSET_BITS) - 64'd1;

    queue_req(REQ_TRANSLATE, '0);
    queue_req(REQ_TRANSLATE, '1);
    queue_req(REQ_ALLOCATE, '0);
    queue_req(REQ_TRANSLATE, make_va(0, 0, 0));
    queue_req(REQ_TRANSLATE, make_va(0, 0, off_max));
    queue_req(REQ_ALLOCATE, '0);
    queue_req(REQ_TRANSLATE, make_va(0, 1, 0));
    queue_req(REQ_TRANSLATE, VA_W'(1) << (VA_W - 1));
    queue_req(REQ_ALLOCATE, '1);
    queue_req(REQ_TRANSLATE, '1);
    queue_req(REQ_ALLOCATE, make_va(0, leaf_max, 0));
    queue_req(REQ_TRANSLATE, make_va(0, leaf_max, 'h5A5));
    queue_req(REQ_TRANSLATE, make_va(1, 0, 0));
    queue_req(REQ_ALLOCATE, make_va(1, 0, 0));
    queue_req(REQ_TRANSLATE, make_va(1, 0, off_max >> 1));
    queue_req(REQ_TRANSLATE, make_va(upper_mask, leaf_max, 0));
    queue_req(REQ_TRANSLATE, make_va(64'd1 << IDX_SIZE, 0, 0));
    queue_req(REQ_ALLOCATE, '1);

    prefix_pool[0] = 0;
    prefix_pool[1] = upper_mask;
    for (int i = 2; i < 8; i++) prefix_pool[i] = {$urandom, $urandom} & upper_mask;

    repeat (RANDOM_ITEMS) begin
      dice = $urandom_range(0, 99);
      if (dice < 30 && tried_allocs.size() > 0) begin
        pick_va = tried_allocs[$urandom_range(0, tried_allocs.size() - 1)];
        pick_va[PAGE_OFFSET_BITS-1:0] =
          PAGE_OFFSET_BITS'($urandom_range(0, int'(off_max)));
        queue_req(REQ_TRANSLATE, pick_va);
      end else if (dice < 45) begin
        queue_req(REQ_ALLOCATE, make_va(prefix_pool[$urandom_range(0, 7)],
                                        64'($urandom_range(0, int'(leaf_max))),
                                        64'($urandom_range(0, int'(off_max)))));
      end else if (dice < 52) begin
        queue_req(REQ_ALLOCATE, VA_W'({$urandom, $urandom}));
      end else if (dice < 60 && tried_allocs.size() > 0) begin
        queue_req(REQ_ALLOCATE, tried_allocs[$urandom_range(0, tried_allocs.size() - 1)]);
      end else if (dice < 80) begin
        queue_req(REQ_TRANSLATE, make_va(prefix_pool[$urandom_range(0, 7)],
                                         64'($urandom_range(0, int'(leaf_max))),
                                         64'($urandom_range(0, int'(off_max)))));
      end else begin
        queue_req(REQ_TRANSLATE, VA_W'({$urandom, $urandom}));
      end
    end

    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;

    do @(negedge clk_i);
    while (pending_reqs.size() != 0 || walk_results_q.size() != 0);
    repeat (4 * WALK_CYCLES) @(negedge clk_i);

    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
